[rtl/postfix_expression_evaluator_assert.svh]
// Assertion macros used by the port-level checker of the postfix evaluator.
// No dependencies; include by bare file name.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PFX_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("postfix evaluator assertion failed");

// Next-cycle implication, disabled during reset.
`define PFX_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("postfix evaluator assertion failed");

`endif

[rtl/pfx_pkg.sv]
// Shared types, character codes and decode functions of the postfix evaluator.
// No dependencies.
`default_nettype none

package pfx_pkg;

    localparam int SYMBOL_W    = 8;
    localparam int OUT_VALUE_W = 32;
    localparam int FLAG_W      = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_EMPTY_BIT = OUT_VALUE_W;

    localparam int FLAG_UNDER = 0;
    localparam int FLAG_OVER  = 1;
    localparam int FLAG_DIVZ  = 2;

    localparam logic [SYMBOL_W-1:0] CH_0     = 8'h30;
    localparam logic [SYMBOL_W-1:0] CH_9     = 8'h39;
    localparam logic [SYMBOL_W-1:0] CH_SPACE = 8'h20;
    localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [1:0] {
        SYM_NONE,
        SYM_DIGIT,
        SYM_OP
    } t_sym_class;

    // Controller to datapath commands.
    typedef struct packed {
        logic latch;
        logic push;
        logic push_digit;
        logic pop;
        logic load_rhs;
        logic load_lhs;
        logic exec;
        logic peek;
        logic emit;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        t_sym_class sym_class;
        logic       last;
        logic       use_md;
        logic       md_done;
        logic       out_busy;
    } t_status;

    function automatic t_sym_class classify(input logic [SYMBOL_W-1:0] sym);
        t_sym_class c;
        c = SYM_NONE;
        case (sym) inside
            [CH_0:CH_9]:                          c = SYM_DIGIT;
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: c = SYM_OP;
            CH_SPACE:                             c = SYM_NONE;
            default:                              c = SYM_NONE;
        endcase
        return c;
    endfunction

    function automatic t_op to_op(input logic [SYMBOL_W-1:0] sym);
        t_op op;
        op = OP_ADD;
        case (sym)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  op = OP_ADD;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

[rtl/pfx_muldiv.sv]
// Shared iterative unit: shift-add multiply and restoring signed divide,
// one bit per cycle. Depends on pfx_pkg.
`default_nettype none

module pfx_muldiv #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire pfx_pkg::t_op           i_op,
    input  wire logic [VALUE_WIDTH-1:0] i_lhs,
    input  wire logic [VALUE_WIDTH-1:0] i_rhs,
    output logic                        o_done,
    output logic [VALUE_WIDTH-1:0]      o_result
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic          r_is_div;
    logic          r_neg;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;

    logic [W-1:0]  w_lhs_mag;
    logic [W-1:0]  w_rhs_mag;
    logic [W:0]    w_rem_sh;
    logic [W:0]    w_diff;
    logic          w_ge;

    assign w_lhs_mag = i_lhs[W-1] ? W'(~i_lhs + 1'b1) : i_lhs;
    assign w_rhs_mag = i_rhs[W-1] ? W'(~i_rhs + 1'b1) : i_rhs;
    assign w_rem_sh  = {r_acc, r_b[W-1]};
    assign w_diff    = w_rem_sh - {1'b0, r_a};
    assign w_ge      = ~w_diff[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_is_div <= (i_op == pfx_pkg::OP_DIV);
            r_neg    <= i_lhs[W-1] ^ i_rhs[W-1];
            r_acc    <= '0;
            if (i_op == pfx_pkg::OP_DIV) begin
                r_a <= w_rhs_mag;
                r_b <= w_lhs_mag;
            end else begin
                r_a <= i_lhs;
                r_b <= i_rhs;
            end
        end else if (r_busy) begin
            if (r_is_div) begin
                // Shift in next dividend bit, subtract when it fits.
                r_acc <= w_ge ? w_diff[W-1:0] : w_rem_sh[W-1:0];
                r_b   <= {r_b[W-2:0], w_ge};
            end else begin
                r_acc <= r_acc + (r_b[0] ? r_a : '0);
                r_a   <= {r_a[W-2:0], 1'b0};
                r_b   <= {1'b0, r_b[W-1:1]};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_is_div ? (r_neg ? W'(~r_b + 1'b1) : r_b) : r_acc;

endmodule

`default_nettype wire

[rtl/pfx_dpath.sv]
// Datapath of the postfix evaluator: operand stack memory, stack count,
// sticky flags, operand registers, multiply/divide unit and result register.
// Depends on pfx_pkg and pfx_muldiv.
`default_nettype none

module pfx_dpath #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pfx_pkg::t_cmd                     i_cmd,
    output pfx_pkg::t_status                       o_status,
    input  wire logic [pfx_pkg::SYMBOL_W-1:0]      i_symbol,
    input  wire logic                              i_last,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [pfx_pkg::OUT_VALUE_W-1:0]        o_out_value,
    output logic                                   o_out_empty,
    output logic [pfx_pkg::FLAG_W-1:0]             o_out_flags
);

    localparam int W     = VALUE_WIDTH;
    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNTW  = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W = (W > pfx_pkg::OUT_VALUE_W) ? W : pfx_pkg::OUT_VALUE_W;

    logic [W-1:0] r_mem [STACK_DEPTH];
    logic [W-1:0] r_rd_data;

    logic [pfx_pkg::SYMBOL_W-1:0] r_sym;
    logic                         r_last;
    logic [CNTW-1:0]              r_count;
    logic [pfx_pkg::FLAG_W-1:0]   r_flags;
    logic                         r_pop_empty;
    logic [W-1:0]                 r_lhs;
    logic [W-1:0]                 r_rhs;
    logic [W-1:0]                 r_res;

    logic                             r_out_valid;
    logic [pfx_pkg::OUT_VALUE_W-1:0]  r_out_value;
    logic                             r_out_empty;
    logic [pfx_pkg::FLAG_W-1:0]       r_out_flags;

    pfx_pkg::t_op    w_op;
    logic            w_zero;
    logic            w_full;
    logic [CNTW-1:0] w_count_m1;
    logic            w_we;
    logic            w_re;
    logic [W-1:0]    w_wdata;
    logic            w_rhs_zero;
    logic            w_use_md;
    logic            w_md_done;
    logic [W-1:0]    w_md_result;
    logic signed [W-1:0]     w_top_s;
    logic signed [EXT_W-1:0] w_top_ext;

    assign w_op       = pfx_pkg::to_op(r_sym);
    assign w_zero     = (r_count == '0);
    assign w_full     = (r_count == CNTW'(STACK_DEPTH));
    assign w_count_m1 = r_count - 1'b1;
    assign w_we       = i_cmd.push && !w_full;
    assign w_re       = i_cmd.pop || i_cmd.peek;
    assign w_wdata    = i_cmd.push_digit ? W'(r_sym[3:0]) : r_res;
    assign w_rhs_zero = (r_rhs == '0);
    assign w_use_md   = (w_op == pfx_pkg::OP_MUL) || ((w_op == pfx_pkg::OP_DIV) && !w_rhs_zero);
    assign w_top_s    = r_rd_data;
    assign w_top_ext  = EXT_W'(w_top_s);

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[AW-1:0]] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_count_m1[AW-1:0]];
        end
    end

    // Control state: count, sticky flags, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_count <= '0;
                r_flags <= '0;
            end else begin
                if (i_cmd.pop) begin
                    if (w_zero) begin
                        r_flags[pfx_pkg::FLAG_UNDER] <= 1'b1;
                    end else begin
                        r_count <= w_count_m1;
                    end
                end
                if (i_cmd.push) begin
                    if (w_full) begin
                        r_flags[pfx_pkg::FLAG_OVER] <= 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
                if (i_cmd.exec && (w_op == pfx_pkg::OP_DIV) && w_rhs_zero) begin
                    r_flags[pfx_pkg::FLAG_DIVZ] <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_sym  <= i_symbol;
            r_last <= i_last;
        end
        if (w_re) begin
            r_pop_empty <= w_zero;
        end
        if (i_cmd.load_rhs) begin
            r_rhs <= r_pop_empty ? '1 : r_rd_data;
        end
        if (i_cmd.load_lhs) begin
            r_lhs <= r_pop_empty ? '1 : r_rd_data;
        end
        if (i_cmd.exec) begin
            case (w_op)
                pfx_pkg::OP_ADD: r_res <= r_lhs + r_rhs;
                pfx_pkg::OP_SUB: r_res <= r_lhs - r_rhs;
                default:         r_res <= '0;
            endcase
        end else if (w_md_done) begin
            r_res <= w_md_result;
        end
        if (i_cmd.emit) begin
            r_out_value <= r_pop_empty ? '1 : w_top_ext[pfx_pkg::OUT_VALUE_W-1:0];
            r_out_empty <= r_pop_empty;
            r_out_flags <= r_flags;
        end
    end

    pfx_muldiv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.exec && w_use_md),
        .i_op     (w_op),
        .i_lhs    (r_lhs),
        .i_rhs    (r_rhs),
        .o_done   (w_md_done),
        .o_result (w_md_result)
    );

    always_comb begin
        o_status.sym_class = pfx_pkg::classify(r_sym);
        o_status.last      = r_last;
        o_status.use_md    = w_use_md;
        o_status.md_done   = w_md_done;
        o_status.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_empty = r_out_empty;
    assign o_out_flags = r_out_flags;

endmodule

`default_nettype wire

[rtl/pfx_ctrl.sv]
// Controller of the postfix evaluator: sequences push, pop, execute and
// result steps for each word. Depends on pfx_pkg.
`default_nettype none

module pfx_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire pfx_pkg::t_status i_status,
    output pfx_pkg::t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_R,
        S_POP_L,
        S_LOAD_L,
        S_EXEC,
        S_WAIT_MD,
        S_PUSH,
        S_PEEK,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   w_accept;

    assign w_accept   = i_in_valid && r_ready;
    assign o_in_ready = r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.latch = w_accept;
                if (w_accept) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_status.sym_class)
                    pfx_pkg::SYM_DIGIT: n_state = S_PUSH;
                    pfx_pkg::SYM_OP:    n_state = S_POP_R;
                    default:            n_state = i_status.last ? S_PEEK : S_IDLE;
                endcase
            end
            S_POP_R: begin
                o_cmd.pop = 1'b1;
                n_state   = S_POP_L;
            end
            S_POP_L: begin
                o_cmd.load_rhs = 1'b1;
                o_cmd.pop      = 1'b1;
                n_state        = S_LOAD_L;
            end
            S_LOAD_L: begin
                o_cmd.load_lhs = 1'b1;
                n_state        = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.use_md ? S_WAIT_MD : S_PUSH;
            end
            S_WAIT_MD: begin
                if (i_status.md_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push       = 1'b1;
                o_cmd.push_digit = (i_status.sym_class == pfx_pkg::SYM_DIGIT);
                n_state          = i_status.last ? S_PEEK : S_IDLE;
            end
            S_PEEK: begin
                o_cmd.peek = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                // Hold until the result register is free.
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

endmodule

`default_nettype wire

[rtl/postfix_expression_evaluator.sv]
// Postfix evaluator, one word per character; it takes the next character only once the
// last is through. + - and / by zero run in the datapath, * and / in the bit-serial unit.
// A final character also reads the stack top and loads the result register,
// and holds while an earlier result word is still pending in the output register.
// Synchronous active-low reset empties the stack, clears the flags and drops any
// pending result; the stack memory itself is not cleared.
`default_nettype none

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input stream: one character per word.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [pfx_pkg::SYMBOL_W-1:0]        s_axis_tdata,  // [7:0] symbol
    input  wire logic                                s_axis_tlast,  // last_symbol
    // Result stream: one word per expression.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [31:0] value, [32] stack_empty, [33] underflow_seen, [34] overflow_seen,
    // [35] divide_by_zero_seen, [39:36] zero
    output logic [pfx_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

    pfx_pkg::t_cmd    w_cmd;
    pfx_pkg::t_status w_status;

    logic [pfx_pkg::OUT_VALUE_W-1:0] w_out_value;
    logic                            w_out_empty;
    logic [pfx_pkg::FLAG_W-1:0]      w_out_flags;

    // Sequencer: walks each character through dispatch and, as its kind needs, pops,
    // execute and push, and on the final character the result step.
    pfx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Stack, operands, arithmetic and the result register.
    pfx_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_symbol    (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_value (w_out_value),
        .o_out_empty (w_out_empty),
        .o_out_flags (w_out_flags)
    );

    // Pack the result word, lowest field first, zero pad to whole bytes.
    assign m_axis_tdata = pfx_pkg::OUT_TDATA_W'({
        w_out_flags[pfx_pkg::FLAG_DIVZ],
        w_out_flags[pfx_pkg::FLAG_OVER],
        w_out_flags[pfx_pkg::FLAG_UNDER],
        w_out_empty,
        w_out_value
    });

endmodule

`default_nettype wire

[rtl/pfx_checker.sv]
// Port-level checks of the postfix evaluator, bound to the top level.
// Depends on pfx_pkg and postfix_expression_evaluator_assert.svh.
`default_nettype none
`include "postfix_expression_evaluator_assert.svh"

module pfx_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [pfx_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // Keep valid high on a stalled result word.
    `PFX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // One character at a time: drop ready right after a word is taken.
    `PFX_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // An empty stack reports minus one.
    `PFX_ASSERT_NOW(a_empty_value, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[pfx_pkg::OUT_EMPTY_BIT], m_axis_tdata[pfx_pkg::OUT_VALUE_W-1:0] == '1)

    // A new result appears only as the block returns to idle.
    `PFX_ASSERT_NOW(a_emit_to_idle, i_clk, i_rst_n, $rose(m_axis_tvalid), s_axis_tready)

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the postfix expression evaluator: streams characters in,
// predicts each expression result and compares it with the result stream.
// Depends on rtl/pfx_pkg.sv and rtl/postfix_expression_evaluator.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     STACK_DEPTH  = 64;
    localparam int     VALUE_WIDTH  = 32;
    localparam int     RESET_CYCLES = 5;
    // Slowest character is a multiply or divide, plus the result step; allow margin.
    localparam int     DRAIN_CYCLES = 100;
    // Long receiver hold-off used to fill the block and stall its input.
    localparam int     HOLD_CYCLES  = 500;
    localparam longint TIMEOUT_NS   = 50_000_000;

    // One expected or observed result word, field by field.
    typedef struct {
        logic [pfx_pkg::OUT_VALUE_W-1:0] value;
        logic                            empty;
        logic                            under;
        logic                            over;
        logic                            divz;
    } t_expr_result;

    // DUT ports; the inputs are driven to known values from time zero.
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [pfx_pkg::SYMBOL_W-1:0]    s_axis_tdata  = '0;   // [7:0] symbol
    logic                            s_axis_tlast  = 1'b0; // last_symbol
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [31:0] value, [32] stack_empty, [33] underflow_seen, [34] overflow_seen,
    // [35] divide_by_zero_seen, [39:36] zero
    logic [pfx_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Predictor state: its own operand stack, depth and sticky flags.
    logic [VALUE_WIDTH-1:0]       calc_stack [STACK_DEPTH];
    int                           calc_depth = 0;
    logic [pfx_pkg::FLAG_W-1:0]   calc_flags = '0;

    // Results predicted but not yet seen on the output, oldest first.
    t_expr_result           pending_results [$];

    // Traffic shaping shared by the sender and the receiver.
    bit                     idling      = 1'b1;
    int                     rx_hold_left = 0;
    int                     rx_gap_left  = 0;

    // Run statistics.
    int                     error_count   = 0;
    int                     n_symbols     = 0;
    int                     n_results     = 0;
    int                     n_empty       = 0;
    int                     n_under       = 0;
    int                     n_over        = 0;
    int                     n_divz        = 0;
    int                     n_input_stall = 0;

    postfix_expression_evaluator #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Push onto the model stack; a full stack drops the value and flags overflow.
    function automatic void calc_push(input logic [VALUE_WIDTH-1:0] v);
        if (calc_depth >= STACK_DEPTH) begin
            calc_flags[pfx_pkg::FLAG_OVER] = 1'b1;
        end else begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
    endfunction

    // Pop from the model stack; an empty stack yields -1 and flags underflow.
    function automatic logic [VALUE_WIDTH-1:0] calc_pop();
        if (calc_depth == 0) begin
            calc_flags[pfx_pkg::FLAG_UNDER] = 1'b1;
            return '1;
        end
        calc_depth--;
        return calc_stack[calc_depth];
    endfunction

    // Advance the model by one accepted character. Returns 1 when the character
    // closes an expression, with the expected result in res; the model then clears.
    function automatic bit evaluate_symbol(input logic [pfx_pkg::SYMBOL_W-1:0] sym,
                                           input logic last,
                                           output t_expr_result res);
        logic [VALUE_WIDTH-1:0] rhs;
        logic [VALUE_WIDTH-1:0] lhs;
        logic [VALUE_WIDTH-1:0] v;
        longint                 quot;
        res = '{default: '0};
        if (sym >= pfx_pkg::CH_0 && sym <= pfx_pkg::CH_9) begin
            calc_push({{(VALUE_WIDTH-pfx_pkg::SYMBOL_W){1'b0}}, sym - pfx_pkg::CH_0});
        end else if (sym == pfx_pkg::CH_PLUS || sym == pfx_pkg::CH_MINUS ||
                     sym == pfx_pkg::CH_STAR || sym == pfx_pkg::CH_SLASH) begin
            // Right operand comes off first.
            rhs = calc_pop();
            lhs = calc_pop();
            case (sym)
                pfx_pkg::CH_PLUS:  v = lhs + rhs;
                pfx_pkg::CH_MINUS: v = lhs - rhs;
                pfx_pkg::CH_STAR:  v = lhs * rhs;
                default: begin
                    if (rhs == '0) begin
                        // Zero divisor: push 0 and flag it.
                        calc_flags[pfx_pkg::FLAG_DIVZ] = 1'b1;
                        v = '0;
                    end else begin
                        // 64-bit signed divide truncates toward zero; the low bits give
                        // the wrap of the most negative value over -1.
                        quot = longint'($signed(lhs)) / longint'($signed(rhs));
                        v = quot[VALUE_WIDTH-1:0];
                    end
                end
            endcase
            calc_push(v);
        end
        if (!last) begin
            return 1'b0;
        end
        res.empty = (calc_depth == 0);
        res.value = res.empty ? '1 : calc_stack[calc_depth-1];
        res.under = calc_flags[pfx_pkg::FLAG_UNDER];
        res.over  = calc_flags[pfx_pkg::FLAG_OVER];
        res.divz  = calc_flags[pfx_pkg::FLAG_DIVZ];
        calc_depth = 0;
        calc_flags = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Traffic shaping
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if (!idling) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [pfx_pkg::SYMBOL_W-1:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return pfx_pkg::CH_PLUS;
            1:       return pfx_pkg::CH_MINUS;
            2:       return pfx_pkg::CH_STAR;
            default: return pfx_pkg::CH_SLASH;
        endcase
    endfunction

    // Receiver: drive tready at the falling edge. A requested hold-off wins, then
    // random gaps, else ready.
    initial begin : rx_drive
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_left--;
            end else if (rx_gap_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_gap_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (idling && $urandom_range(0, 2) == 0) begin
                    rx_gap_left = pick_gap();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      n_results, name, got, want));
        end
    endtask

    // Sample every handshake at the rising edge and compare with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_expr_result want;
        if (i_rst_n && s_axis_tvalid && !s_axis_tready) begin
            n_input_stall++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word %0h with no expression pending",
                                          m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                compare_field("value", m_axis_tdata[pfx_pkg::OUT_VALUE_W-1:0], want.value);
                compare_field("stack_empty",
                              32'(m_axis_tdata[pfx_pkg::OUT_EMPTY_BIT]), 32'(want.empty));
                compare_field("underflow_seen",
                              32'(m_axis_tdata[pfx_pkg::OUT_EMPTY_BIT+1+pfx_pkg::FLAG_UNDER]),
                              32'(want.under));
                compare_field("overflow_seen",
                              32'(m_axis_tdata[pfx_pkg::OUT_EMPTY_BIT+1+pfx_pkg::FLAG_OVER]),
                              32'(want.over));
                compare_field("divide_by_zero_seen",
                              32'(m_axis_tdata[pfx_pkg::OUT_EMPTY_BIT+1+pfx_pkg::FLAG_DIVZ]),
                              32'(want.divz));
                compare_field("padding",
                              32'(m_axis_tdata[pfx_pkg::OUT_TDATA_W-1:
                                               pfx_pkg::OUT_EMPTY_BIT+1+pfx_pkg::FLAG_W]),
                              '0);
                n_empty += want.empty;
                n_under += want.under;
                n_over  += want.over;
                n_divz  += want.divz;
            end
            n_results++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one character and hold it until accepted. Enter and leave at a falling
    // edge; valid stays high on exit so back-to-back words need no re-raise.
    task automatic send_symbol(input logic [pfx_pkg::SYMBOL_W-1:0] sym, input logic last);
        int           gap;
        t_expr_result res;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        // Accepted: advance the predictor.
        if (evaluate_symbol(sym, last, res)) begin
            pending_results.push_back(res);
        end
        if ((sym >= pfx_pkg::CH_0 && sym <= pfx_pkg::CH_9) ||
            sym == pfx_pkg::CH_PLUS || sym == pfx_pkg::CH_MINUS ||
            sym == pfx_pkg::CH_STAR || sym == pfx_pkg::CH_SLASH) begin
            n_symbols++;
        end
        @(negedge i_clk);
    endtask

    // Send a string as one expression, last flag on its final character.
    task automatic send_text(input string text);
        for (int k = 0; k < text.len(); k++) begin
            send_symbol(text[k], k == text.len() - 1);
        end
    endtask

    // Blank expression, bytes outside the alphabet, single digits at both ends.
    task automatic test_ignored_symbols();
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol("a", 1'b0);
        send_symbol(pfx_pkg::CH_SPACE, 1'b1);
        send_text("0");
        send_text("9");
        // Final character ignored, with a value below it.
        send_symbol("5", 1'b0);
        send_symbol(8'h80, 1'b1);
    endtask

    // Each operator at least once, the last character being the operator itself.
    task automatic test_operators();
        send_text("73+");
        send_text("37-");
        send_text("98*");
        send_text("9 2/");
        // 7 / -3 truncates toward zero.
        send_text("703-/");
    endtask

    // Operators on an empty or one-deep stack: -1 operands, sticky underflow.
    task automatic test_underflow();
        send_text("+");
        send_text("5-");
    endtask

    task automatic test_divide_by_zero();
        send_text("50/");
        send_text("60/2+");
    endtask

    // Build 8^10 * 2 = 2^31, which wraps to the most negative value, then divide by -1.
    task automatic test_min_over_minus_one();
        send_symbol("8", 1'b0);
        repeat (9) begin
            send_symbol("8", 1'b0);
            send_symbol(pfx_pkg::CH_STAR, 1'b0);
        end
        send_text("2*01-/");
    endtask

    // Fill the stack and push once more: the extra digit is dropped.
    task automatic test_overflow();
        for (int k = 0; k < STACK_DEPTH; k++) begin
            send_symbol(pfx_pkg::CH_0 + 8'(k % 10), 1'b0);
        end
        send_symbol("7", 1'b1);
    endtask

    // Hold the receiver off for a long stretch while characters keep coming, so the
    // pending result register fills and the input stalls.
    task automatic test_output_backpressure();
        bit saved;
        saved = idling;
        idling = 1'b0;
        rx_hold_left = HOLD_CYCLES;
        repeat (12) send_text("12+3*");
        idling = saved;
    endtask

    // One random expression: mostly well formed with random content, some broken
    // sequences of valid characters and some raw byte noise.
    task automatic send_random_expression();
        logic [pfx_pkg::SYMBOL_W-1:0] expr [$];
        int                           kind;
        int                           len;
        int                           depth;
        int                           pushes_left;
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
            len = $urandom_range(1, 8);
            repeat (len) expr.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 5) begin
            len = $urandom_range(1, 12);
            repeat (len) begin
                case ($urandom_range(0, 5))
                    0, 1, 2: expr.push_back(pfx_pkg::CH_0 + 8'($urandom_range(0, 9)));
                    3, 4:    expr.push_back(pick_operator());
                    default: expr.push_back(pfx_pkg::CH_SPACE);
                endcase
            end
        end else begin
            // Deep case pushes 60 to 70 digits, around the stack depth, before reducing.
            pushes_left = (kind == 19) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            depth = 0;
            while (pushes_left > 0 || depth > 1) begin
                if (depth >= 2 &&
                    (pushes_left == 0 || (kind != 19 && $urandom_range(0, 2) == 0))) begin
                    expr.push_back(pick_operator());
                    depth--;
                end else begin
                    expr.push_back(pfx_pkg::CH_0 + 8'($urandom_range(0, 9)));
                    pushes_left--;
                    depth++;
                end
                if ($urandom_range(0, 7) == 0) begin
                    expr.push_back(pfx_pkg::CH_SPACE);
                end
            end
        end
        foreach (expr[k]) begin
            send_symbol(expr[k], k == expr.size() - 1);
        end
    endtask

    task automatic test_random_expressions(input int symbol_budget);
        int stop_at;
        stop_at = n_symbols + symbol_budget;
        while (n_symbols < stop_at) begin
            send_random_expression();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_ignored_symbols();
        test_operators();
        test_underflow();
        test_divide_by_zero();
        test_min_over_minus_one();
        test_overflow();
        test_output_backpressure();

        idling = 1'b1;
        test_random_expressions(500);
        idling = 1'b0;
        test_random_expressions(250);
        idling = 1'b1;
        test_random_expressions(750);

        // Drop valid, drain all expected results, then watch for stray words.
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d digit/operator characters into %0d expression results, %0d stall cycles.",
                 n_symbols, n_results, n_input_stall);
        $display("Empty stack %0d, underflow %0d, overflow %0d, div-by-zero %0d; %0d mismatches.",
                 n_empty, n_under, n_over, n_divz, error_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/pfx_pkg.sv
rtl/pfx_muldiv.sv
rtl/pfx_dpath.sv
rtl/pfx_ctrl.sv
rtl/postfix_expression_evaluator.sv
rtl/pfx_checker.sv
dv/tb.sv
